FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define QMN_AST_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("qmn assertion failed");

// Next-cycle implication, disabled while reset is low.
`define QMN_AST_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("qmn assertion failed");

`endif

FILE: hw/rtl/qmn_pkg.sv
// Widths, types and helper functions for the quaternion product normalizer.
`default_nettype none
package qmn_pkg;

	localparam int COMP_WIDTH = 16;
	localparam int FRAC_BITS  = 14;
	localparam int MANT_BITS  = 30;
	localparam int MAGREG_W   = 8;

	localparam int PROD_SHIFT = (2 * COMP_WIDTH > 62) ? (2 * COMP_WIDTH - 62) : 0;
	localparam int FULL_W     = 2 * COMP_WIDTH;
	localparam int PROD_W     = FULL_W - PROD_SHIFT;
	localparam int SUM_W      = PROD_W + 2;
	localparam int MAG_W      = SUM_W;
	localparam int LEN_W      = $clog2(MAG_W + 1);
	localparam int SQ_W       = 2 * MANT_BITS;
	localparam int ACC_W      = SQ_W + 2;
	localparam int ROOT_W     = ACC_W / 2;
	localparam int T_W        = MAGREG_W + FRAC_BITS - PROD_SHIFT;
	localparam int CMP_W      = T_W + MANT_BITS + 1;
	localparam int NUM_W      = MANT_BITS + FRAC_BITS + 1;
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int EXT_W      = ((QUO_W > COMP_WIDTH) ? QUO_W : COMP_WIDTH) + 1;

	localparam logic [EXT_W-1:0] HALF_EXT = EXT_W'(1) << (COMP_WIDTH - 1);
	localparam logic [EXT_W-1:0] ONE_EXT  = EXT_W'(1) << FRAC_BITS;
	localparam logic [COMP_WIDTH-1:0] ONE_SAT =
		(ONE_EXT > HALF_EXT - EXT_W'(1)) ? COMP_WIDTH'(HALF_EXT - EXT_W'(1))
		                                 : COMP_WIDTH'(ONE_EXT);

	typedef logic [3:0][COMP_WIDTH-1:0] quat_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] psum_t;

	// Per-item side data that travels beside the root pipeline.
	typedef struct packed {
		logic                       zero;
		logic                       dir_right;
		logic [LEN_W-1:0]           k;
		logic [3:0]                 neg;
		logic [3:0][MANT_BITS-1:0]  qmag;
	} side_t;

	// Truncate a full product toward zero by PROD_SHIFT bits.
	function automatic prod_t prod_trunc(input logic signed [FULL_W-1:0] x);
		logic [FULL_W:0] mag;
		logic [FULL_W:0] sh;
		begin
			mag = x[FULL_W-1] ? (FULL_W+1)'(-$signed({x[FULL_W-1], x}))
			                  : (FULL_W+1)'({x[FULL_W-1], x});
			sh  = mag >> PROD_SHIFT;
			prod_trunc = x[FULL_W-1] ? PROD_W'(-$signed(sh)) : PROD_W'(sh);
		end
	endfunction

	// Bit length of an unsigned magnitude.
	function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] v);
		logic [LEN_W-1:0] len;
		begin
			len = '0;
			for (int i = 0; i < MAG_W; i++) begin
				if (v[i]) begin
					len = LEN_W'(i + 1);
				end
			end
			bit_len = len;
		end
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/qmn_product.sv
// Hamilton product: component multiplies, then the four signed sums.
`default_nettype none
module qmn_product import qmn_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire logic  cmd,
	input  wire quat_t a_in,
	input  wire quat_t b_in,
	output logic       out_valid,
	output psum_t      p_out [4]
);

	logic  v_s1, v_s2;
	prod_t prod_s1 [4][4];
	psum_t p_s2 [4];
	quat_t a_sel, b_sel;

	always_comb begin
		a_sel = cmd ? b_in : a_in;
		b_sel = cmd ? a_in : b_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= prod_trunc(
						$signed(a_sel[i]) * $signed(b_sel[j]));
				end
			end
			p_s2[0] <= SUM_W'(prod_s1[0][0]) - SUM_W'(prod_s1[1][1])
			         - SUM_W'(prod_s1[2][2]) - SUM_W'(prod_s1[3][3]);
			p_s2[1] <= SUM_W'(prod_s1[0][1]) + SUM_W'(prod_s1[1][0])
			         + SUM_W'(prod_s1[2][3]) - SUM_W'(prod_s1[3][2]);
			p_s2[2] <= SUM_W'(prod_s1[0][2]) - SUM_W'(prod_s1[1][3])
			         + SUM_W'(prod_s1[2][0]) + SUM_W'(prod_s1[3][1]);
			p_s2[3] <= SUM_W'(prod_s1[0][3]) + SUM_W'(prod_s1[1][2])
			         - SUM_W'(prod_s1[2][1]) + SUM_W'(prod_s1[3][0]);
		end
	end

	assign out_valid = v_s2;
	assign p_out     = p_s2;

endmodule
`default_nettype wire

FILE: hw/rtl/qmn_scale.sv
// Block scaling to a 30-bit mantissa, squares and sum of squares.
`default_nettype none
module qmn_scale import qmn_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire psum_t p_in [4],
	output logic       out_valid,
	output logic [ACC_W-1:0] acc_out,
	output side_t      side_out
);

	logic v_s3, v_s4, v_s5, v_s6;
	logic [3:0][MAG_W-1:0] mag_s3;
	logic [3:0]            neg_s3;
	logic [LEN_W-1:0]      len_s3;
	side_t                 side_s4, side_s5, side_s6;
	logic [SQ_W-1:0]       sq_s5 [4];
	logic [ACC_W-1:0]      acc_s6;

	logic [3:0][MAG_W-1:0] mag_c;
	logic [MAG_W-1:0]      or_c;
	logic                  right_c;
	logic [LEN_W-1:0]      k_c;
	logic [MAG_W-1:0]      sh_c [4];

	always_comb begin
		or_c = '0;
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = p_in[i][SUM_W-1] ? MAG_W'(-p_in[i]) : MAG_W'(p_in[i]);
			or_c     = or_c | mag_c[i];
		end
	end

	// Largest magnitude and the OR of all magnitudes share their bit length.
	always_comb begin
		right_c = len_s3 > LEN_W'(MANT_BITS);
		k_c     = right_c ? len_s3 - LEN_W'(MANT_BITS) : LEN_W'(MANT_BITS) - len_s3;
		for (int i = 0; i < 4; i++) begin
			sh_c[i] = right_c ? (mag_s3[i] >> k_c) : (mag_s3[i] << k_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= mag_c;
			len_s3 <= bit_len(or_c);
			for (int i = 0; i < 4; i++) begin
				neg_s3[i] <= p_in[i][SUM_W-1];
			end

			side_s4.zero      <= (len_s3 == '0);
			side_s4.dir_right <= right_c;
			side_s4.k         <= k_c;
			side_s4.neg       <= neg_s3;
			for (int i = 0; i < 4; i++) begin
				side_s4.qmag[i] <= sh_c[i][MANT_BITS-1:0];
			end

			side_s5 <= side_s4;
			for (int i = 0; i < 4; i++) begin
				sq_s5[i] <= side_s4.qmag[i] * side_s4.qmag[i];
			end

			side_s6 <= side_s5;
			acc_s6  <= ACC_W'(sq_s5[0]) + ACC_W'(sq_s5[1])
			         + ACC_W'(sq_s5[2]) + ACC_W'(sq_s5[3]);
		end
	end

	assign out_valid = v_s6;
	assign acc_out   = acc_s6;
	assign side_out  = side_s6;

endmodule
`default_nettype wire

FILE: hw/rtl/qmn_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module qmn_isqrt import qmn_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire logic [ACC_W-1:0] acc_in,
	input  wire side_t side_in,
	output logic       out_valid,
	output logic [ROOT_W-1:0] root_out,
	output side_t      side_out
);

	logic             v_s  [ROOT_W+1];
	logic [ACC_W-1:0] rad_s [ROOT_W+1];
	logic [ACC_W-1:0] res_s [ROOT_W+1];
	side_t            side_s [ROOT_W+1];

	assign v_s[0]    = in_valid;
	assign rad_s[0]  = acc_in;
	assign res_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_step
		localparam logic [ACC_W-1:0] BITV = ACC_W'(1) << (ACC_W - 2 - 2 * j);
		logic [ACC_W-1:0] trial;
		logic             take;

		always_comb begin
			trial = res_s[j] + BITV;
			take  = rad_s[j] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[j+1] <= side_s[j];
				if (take) begin
					rad_s[j+1] <= rad_s[j] - trial;
					res_s[j+1] <= (res_s[j] >> 1) + BITV;
				end else begin
					rad_s[j+1] <= rad_s[j];
					res_s[j+1] <= res_s[j] >> 1;
				end
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root_out  = res_s[ROOT_W][ROOT_W-1:0];
	assign side_out  = side_s[ROOT_W];

endmodule
`default_nettype wire

FILE: hw/rtl/qmn_divide.sv
// Threshold test, restoring division of each component by the root, saturation.
`default_nettype none
module qmn_divide import qmn_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire logic [ROOT_W-1:0] root_in,
	input  wire side_t side_in,
	input  wire logic [MAGREG_W-1:0] min_magnitude,
	output logic       out_valid,
	output quat_t      r_out,
	output logic       degenerate
);

	logic [CMP_W-1:0] t_c, m_c, tsh_c;
	logic             above_c;

	logic                   v_s    [QUO_W+1];
	logic                   deg_s  [QUO_W+1];
	logic [3:0]             neg_s  [QUO_W+1];
	logic [ROOT_W-1:0]      m_s    [QUO_W+1];
	logic [3:0][NUM_W-1:0]  rem_s  [QUO_W+1];
	logic [3:0][QUO_W-1:0]  quo_s  [QUO_W+1];

	always_comb begin
		t_c = CMP_W'(min_magnitude) << (FRAC_BITS - PROD_SHIFT);
		m_c = CMP_W'(root_in);
		if (side_in.dir_right) begin
			tsh_c   = t_c >> side_in.k;
			above_c = m_c > tsh_c;
		end else begin
			tsh_c   = t_c << side_in.k;
			above_c = !(t_c > (m_c >> side_in.k)) && (m_c > tsh_c);
		end
	end

	// Entry stage: decide degenerate, form rounded numerators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			deg_s[0] <= side_in.zero || !above_c || (root_in == '0);
			neg_s[0] <= side_in.neg;
			m_s[0]   <= root_in;
			quo_s[0] <= '0;
			for (int i = 0; i < 4; i++) begin
				rem_s[0][i] <= (NUM_W'(side_in.qmag[i]) << FRAC_BITS)
				             + NUM_W'(root_in >> 1);
			end
		end
	end

	for (genvar s = 0; s < QUO_W; s++) begin : g_div
		localparam int QB = QUO_W - 1 - s;
		logic [NUM_W-1:0] dv;

		assign dv = NUM_W'(m_s[s]) << QB;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[s+1] <= 1'b0;
			end else if (en) begin
				v_s[s+1] <= v_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				deg_s[s+1] <= deg_s[s];
				neg_s[s+1] <= neg_s[s];
				m_s[s+1]   <= m_s[s];
				for (int i = 0; i < 4; i++) begin
					if (rem_s[s][i] >= dv) begin
						rem_s[s+1][i]     <= rem_s[s][i] - dv;
						quo_s[s+1][i]     <= quo_s[s][i] | (QUO_W'(1) << QB);
					end else begin
						rem_s[s+1][i]     <= rem_s[s][i];
						quo_s[s+1][i]     <= quo_s[s][i];
					end
				end
			end
		end
	end

	// Saturate and apply the sign; substitute identity when degenerate.
	always_comb begin
		logic [EXT_W-1:0] qe;
		logic [EXT_W-1:0] lim;
		for (int i = 0; i < 4; i++) begin
			qe  = EXT_W'(quo_s[QUO_W][i]);
			lim = neg_s[QUO_W][i] ? HALF_EXT : HALF_EXT - EXT_W'(1);
			if (qe > lim) begin
				qe = lim;
			end
			r_out[i] = neg_s[QUO_W][i] ? COMP_WIDTH'(-qe) : COMP_WIDTH'(qe);
		end
		if (deg_s[QUO_W]) begin
			r_out    = '0;
			r_out[0] = ONE_SAT;
		end
	end

	assign out_valid  = v_s[QUO_W];
	assign degenerate = deg_s[QUO_W];

endmodule
`default_nettype wire

FILE: hw/rtl/quaternion_multiply_normalize_top.sv
// Top level: stream ports, threshold register, pipeline and output register.
`default_nettype none
// Normalized Hamilton quaternion product. One item (A, B, order select) is
// taken per cycle and one result leaves per cycle while the pipeline is not
// held. From input accept to output valid an item passes the products and
// sums, block scaling and sum of squares, the square root (one root bit per
// stage, which sets most of the depth), the threshold test, the restoring
// divide (one quotient bit per stage, four lanes) and the output register.
// The whole pipeline holds only when the output register is full, not taken
// and the last stage carries an item; empty slots are squeezed out meanwhile.
// min_magnitude is written through cfg_* and should change only while idle.
module quaternion_multiply_normalize_top import qmn_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
	input  wire logic [0:0]   s_axis_tuser,  // cmd
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [63:0]       m_axis_tdata,  // r_w, r_x, r_y, r_z
	output logic [0:0]        m_axis_tuser,  // degenerate
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_data       // min_magnitude
);

	logic [MAGREG_W-1:0] min_magnitude_q;
	logic                en;
	quat_t               a_in, b_in;
	logic                prod_v, scale_v, root_v, div_v;
	psum_t               p_w [4];
	logic [ACC_W-1:0]    acc_w;
	side_t               side_a, side_b;
	logic [ROOT_W-1:0]   root_w;
	quat_t               r_w;
	logic                deg_w;
	logic                out_v_q;
	quat_t               r_q;
	logic                deg_q;
	logic                load;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_magnitude_q <= '0;
		end else if (cfg_valid) begin
			min_magnitude_q <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			a_in[i] = s_axis_tdata[COMP_WIDTH*i +: COMP_WIDTH];
			b_in[i] = s_axis_tdata[COMP_WIDTH*(i+4) +: COMP_WIDTH];
		end
	end

	// Hold everything only when a finished item has nowhere to go.
	assign en            = !(out_v_q && !m_axis_tready && div_v);
	assign s_axis_tready = en;
	assign load          = !out_v_q || m_axis_tready;

	qmn_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.cmd       (s_axis_tuser[0]),
		.a_in      (a_in),
		.b_in      (b_in),
		.out_valid (prod_v),
		.p_out     (p_w)
	);

	qmn_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prod_v),
		.p_in      (p_w),
		.out_valid (scale_v),
		.acc_out   (acc_w),
		.side_out  (side_a)
	);

	qmn_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (scale_v),
		.acc_in    (acc_w),
		.side_in   (side_a),
		.out_valid (root_v),
		.root_out  (root_w),
		.side_out  (side_b)
	);

	qmn_divide u_divide (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (root_v),
		.root_in       (root_w),
		.side_in       (side_b),
		.min_magnitude (min_magnitude_q),
		.out_valid     (div_v),
		.r_out         (r_w),
		.degenerate    (deg_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= div_v;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r_q   <= r_w;
			deg_q <= deg_w;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = deg_q;
	assign m_axis_tdata  = {r_q[3], r_q[2], r_q[1], r_q[0]};

endmodule
`default_nettype wire

FILE: hw/rtl/qmn_checker.sv
// Port-level checker for the quaternion normalizer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module qmn_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [63:0]  m_axis_tdata,
	input wire logic [0:0]   m_axis_tuser
);

	`QMN_AST_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
	`QMN_AST_IMP(a_identity, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[15:0] == 16'd16384 && m_axis_tdata[63:16] == 48'd0)
	`QMN_AST_IMP(a_unit_nonzero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata != 64'd0)
	`QMN_AST_IMP(a_empty_ready, clk, arst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind quaternion_multiply_normalize_top qmn_checker u_qmn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

FILE: sim/tb_quaternion_multiply_normalize_top.sv
// Self-checking testbench for the normalized quaternion product block.
`timescale 1ns / 100ps

module tb_quaternion_multiply_normalize_top;
	import qmn_pkg::*;

	localparam int LATENCY = 55;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 350;

	typedef struct packed {
		logic             cmd;
		logic [127:0]     comps;
	} qpair_t;

	typedef struct packed {
		logic [3:0][15:0] r;
		logic             degenerate;
	} qres_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [0:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_data;

	qpair_t pending_q[$];
	qres_t  product_q[$];
	logic [7:0] min_mag;
	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int n_results;
	int n_degenerate;
	int cycles;
	bit in_taken;

	quaternion_multiply_normalize_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Hamilton product, block scaled, divided by its integer root magnitude.
	function automatic qres_t hamilton_norm(input logic cmd, input logic [127:0] d,
			input logic [7:0] mm);
		longint a[4], b[4], p[4], q[4], tmp;
		longint unsigned mx, sum, m, t, bitv, num, quo, mg;
		int len, k;
		bit above;
		qres_t res;
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'($signed(d[16*i +: 16]));
			b[i] = longint'($signed(d[64 + 16*i +: 16]));
		end
		if (cmd) begin
			for (int i = 0; i < 4; i++) begin
				tmp = a[i]; a[i] = b[i]; b[i] = tmp;
			end
		end
		p[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
		p[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
		p[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
		p[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
		t = longint'(mm) << FRAC_BITS;
		mx = 0;
		for (int i = 0; i < 4; i++) begin
			mg = p[i] < 0 ? -p[i] : p[i];
			if (mg > mx) mx = mg;
		end
		len = 0;
		while (len < 64 && (mx >> len) != 0) len++;
		m = 0;
		above = 0;
		k = 0;
		if (mx != 0) begin
			k = len > MANT_BITS ? len - MANT_BITS : MANT_BITS - len;
			for (int i = 0; i < 4; i++) begin
				if (len > MANT_BITS)
					q[i] = p[i] < 0 ? -((-p[i]) >> k) : (p[i] >> k);
				else
					q[i] = p[i] << k;
			end
			sum = 0;
			for (int i = 0; i < 4; i++) begin
				mg = q[i] < 0 ? -q[i] : q[i];
				sum += mg * mg;
			end
			// integer square root, two bits per step
			bitv = 64'd1 << 62;
			while (bitv > sum) bitv >>= 2;
			while (bitv != 0) begin
				if (sum >= m + bitv) begin
					sum -= m + bitv;
					m = (m >> 1) + bitv;
				end else begin
					m >>= 1;
				end
				bitv >>= 2;
			end
			if (len > MANT_BITS) above = m > (t >> k);
			else if (t > (m >> k)) above = 0;
			else above = m > (t << k);
		end
		if (!above || m == 0) begin
			res.r = '0;
			res.r[0] = ONE_SAT;
			res.degenerate = 1'b1;
			return res;
		end
		for (int i = 0; i < 4; i++) begin
			mg = q[i] < 0 ? -q[i] : q[i];
			num = (mg << FRAC_BITS) + (m >> 1);
			quo = num / m;
			if (q[i] < 0) begin
				if (quo > 32768) quo = 32768;
				res.r[i] = 16'(-longint'(quo));
			end else begin
				if (quo > 32767) quo = 32767;
				res.r[i] = 16'(quo);
			end
		end
		res.degenerate = 1'b0;
		return res;
	endfunction

	// Random component with a random scale so that tiny products show up too.
	function automatic logic [15:0] rand_comp();
		logic signed [15:0] v;
		v = 16'($urandom);
		return v >>> $urandom_range(0, 15);
	endfunction

	function automatic qpair_t rand_pair();
		qpair_t it;
		int mode;
		mode = $urandom_range(0, 3);
		it.cmd = $urandom_range(0, 1);
		for (int i = 0; i < 8; i++)
			it.comps[16*i +: 16] = (mode == 0) ? 16'($urandom) : rand_comp();
		return it;
	endfunction

	// Track handshakes and check results.
	always @(posedge clk) begin
		qres_t got, want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
		in_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_taken)
			product_q.push_back(hamilton_norm(s_axis_tuser[0], s_axis_tdata, min_mag));
		if (arst_n && cfg_valid && cfg_ready)
			min_mag <= cfg_data;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.r = m_axis_tdata;
			got.degenerate = m_axis_tuser[0];
			if (product_q.size() == 0) begin
				$display("%0t: unexpected result r=%h deg=%b", $time, got.r, got.degenerate);
				errors++;
			end else begin
				want = product_q.pop_front();
				n_results++;
				if (want.degenerate) n_degenerate++;
				for (int i = 0; i < 4; i++)
					if (got.r[i] !== want.r[i]) begin
						$display("%0t: r[%0d] expected %h actual %h", $time, i,
							want.r[i], got.r[i]);
						errors++;
					end
				if (got.degenerate !== want.degenerate) begin
					$display("%0t: degenerate expected %b actual %b", $time,
						want.degenerate, got.degenerate);
					errors++;
				end
			end
		end
	end

	// Drive items and output backpressure on the falling edge.
	always @(negedge clk) begin
		qpair_t it;
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			if (!s_axis_tvalid || in_taken) begin
				if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					it = pending_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= it.comps;
					s_axis_tuser <= it.cmd;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic drain();
		while (pending_q.size() != 0 || s_axis_tvalid || product_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_min_mag(input logic [7:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_pair(input logic cmd, input logic [15:0] aw, ax, ay, az,
			bw, bx, by, bz);
		qpair_t it;
		it.cmd = cmd;
		it.comps = {bz, by, bx, bw, az, ay, ax, aw};
		pending_q.push_back(it);
	endtask

	initial begin
		int send_set[5];
		int recv_set[5];
		logic [7:0] mm_set[5];
		send_set = '{0, 82, 0, 20, 0};
		recv_set = '{0, 0, 82, 20, 0};
		mm_set = '{8'd0, 8'd255, 8'd1, 8'd37, 8'd0};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		min_mag = '0;
		errors = 0;
		n_results = 0;
		n_degenerate = 0;
		cycles = 0;
		in_taken = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < 5; ph++) begin
			if (ph != 0) write_min_mag(mm_set[ph]);
			send_idle_pct = send_set[ph];
			recv_stall_pct = recv_set[ph];
			if (ph == 0 || ph == 1) begin
				// zero product, identity, extremes, both orders, tiny products
				push_pair(0, 0, 0, 0, 0, 0, 0, 0, 0);
				push_pair(1, 16'h4000, 0, 0, 0, 0, 0, 0, 0);
				push_pair(0, 16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0);
				push_pair(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
					16'h8000, 16'h8000, 16'h8000, 16'h8000);
				push_pair(1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
					16'h8000, 16'h8000, 16'h8000, 16'h8000);
				push_pair(0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
					16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
				push_pair(0, 0, 16'h2000, 16'h1000, 0, 0, 16'h1000, 16'h3000, 16'h0800);
				push_pair(1, 0, 16'h2000, 16'h1000, 0, 0, 16'h1000, 16'h3000, 16'h0800);
				push_pair(0, 1, 0, 0, 0, 1, 0, 0, 0);
				push_pair(0, 16'hffff, 1, 16'hffff, 1, 1, 1, 16'hffff, 16'hffff);
				push_pair(0, 16'd128, 0, 0, 0, 16'd128, 0, 0, 0);
				push_pair(0, 16'd4096, 0, 0, 0, 16'd1024, 0, 0, 0);
				push_pair(1, 16'd4096, 0, 0, 0, 16'd1020, 0, 0, 0);
				push_pair(0, 16'd16384, 0, 0, 0, 16'd256, 0, 0, 0);
				push_pair(0, 16'd16384, 0, 0, 0, 16'd255, 0, 0, 0);
				push_pair(1, 0, 16'hc000, 0, 0, 0, 0, 16'h4000, 0);
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_q.push_back(rand_pair());
			drain();
		end
		$display("Ran %0d quaternion products over 5 threshold and flow-control phases,",
			n_results);
		$display("%0d of them fell back to the identity.", n_degenerate);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
